// ----- hdl/lz77_sliding_window_encoder_defines.svh -----
// assertion macros shared by the checker
`ifndef LZ77_SLIDING_WINDOW_ENCODER_DEFINES_SVH
`define LZ77_SLIDING_WINDOW_ENCODER_DEFINES_SVH

// same-cycle implication, off during reset
`define LZSE_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lzse check failed");

// next-cycle implication, off during reset
`define LZSE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lzse check failed");

`endif

// ----- hdl/lzse_pkg.sv -----
package lzse_pkg;

   localparam int SEARCH_SIZE = 15;
   localparam int MAX_MATCH   = 15;
   localparam int LOOK_SIZE   = MAX_MATCH + 1;
   localparam int WIN_DEPTH   = SEARCH_SIZE + LOOK_SIZE;
   localparam int HIST_W      = 4;
   localparam int PEND_W      = 5;
   localparam int IDX_W       = 5;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic write;
      logic load;
      logic step;
      logic commit;
      logic last;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic step_go;
      logic out_free;
      logic will_empty;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_MATCH = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

// ----- hdl/lzse_dp.sv -----
module lzse_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  lzse_pkg::dp_cmd_type  cmd,
   output lzse_pkg::dp_status_type status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_match_offset,
   output logic [3:0]            rsp_match_length,
   output logic [7:0]            rsp_literal_byte,
   output logic                  rsp_literal_valid,
   output logic                  rsp_token_last
);
   import lzse_pkg::*;

   // the cursor sits at a fixed slot: history below it, lookahead from it up
   byte_type window_ff [WIN_DEPTH];
   byte_type scan_ff   [WIN_DEPTH];
   byte_type scan_sh   [WIN_DEPTH];

   logic [SEARCH_SIZE:1] alive_ff;
   logic [SEARCH_SIZE:1] match;
   logic [HIST_W-1:0]    len_ff;
   logic [HIST_W-1:0]    hist_ff;
   logic [HIST_W-1:0]    hist_in;
   logic [PEND_W-1:0]    pend_ff;
   logic [PEND_W-1:0]    pend_in;
   logic [HIST_W-1:0]    lim;
   logic [HIST_W-1:0]    best_off;
   logic [IDX_W-1:0]     wr_idx;
   logic [PEND_W-1:0]    used;
   logic [PEND_W-1:0]    hist_sum;
   logic                 has_lit;
   logic                 step_go;
   logic                 out_free;

   logic                 rsp_valid_ff;
   logic [3:0]           off_ff;
   logic [3:0]           mlen_ff;
   logic [7:0]           lit_ff;
   logic                 lit_valid_ff;
   logic                 last_ff;

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         scan_sh[i] = (i < WIN_DEPTH - 1) ? scan_ff[(i + 1) % WIN_DEPTH] : '0;
      end
      for (int d = 1; d <= SEARCH_SIZE; d++) begin
         match[d] = alive_ff[d] && (scan_ff[SEARCH_SIZE - d] == scan_ff[SEARCH_SIZE]);
      end
      // oldest surviving position wins a tie
      best_off = '0;
      for (int d = 1; d <= SEARCH_SIZE; d++) begin
         if (alive_ff[d]) begin
            best_off = HIST_W'(d);
         end
      end
   end

   assign lim      = (pend_ff >= PEND_W'(MAX_MATCH)) ? HIST_W'(MAX_MATCH) : pend_ff[HIST_W-1:0];
   assign step_go  = (len_ff < lim) && (|match);
   assign wr_idx   = IDX_W'(SEARCH_SIZE) + IDX_W'(pend_ff);
   assign has_lit  = {1'b0, len_ff} < pend_ff;
   assign used     = {1'b0, len_ff} + PEND_W'(has_lit);
   assign hist_sum = {1'b0, hist_ff} + used;
   assign hist_in  = (hist_sum > PEND_W'(SEARCH_SIZE)) ? HIST_W'(SEARCH_SIZE)
                                                       : hist_sum[HIST_W-1:0];
   assign pend_in  = pend_ff - used;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.fill_last  = (pend_ff == PEND_W'(LOOK_SIZE - 1));
   assign status.step_go    = step_go;
   assign status.out_free   = out_free;
   assign status.will_empty = (used == pend_ff);

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         window_ff[wr_idx] <= req_data_byte;
      end else if (cmd.commit) begin
         // slide by the match length, one more when a literal is taken
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= has_lit ? scan_sh[i] : scan_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            scan_ff[i] <= window_ff[i];
         end
         for (int d = 1; d <= SEARCH_SIZE; d++) begin
            alive_ff[d] <= (HIST_W'(d) <= hist_ff);
         end
         len_ff <= '0;
      end else if (cmd.step && step_go) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            scan_ff[i] <= scan_sh[i];
         end
         alive_ff <= match;
         len_ff   <= len_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         pend_ff <= '0;
      end else if (cmd.write) begin
         pend_ff <= pend_ff + 1'b1;
      end else if (cmd.commit) begin
         if (cmd.last) begin
            hist_ff <= '0;
            pend_ff <= '0;
         end else begin
            hist_ff <= hist_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         off_ff       <= (len_ff == '0) ? '0 : best_off;
         mlen_ff      <= len_ff;
         lit_ff       <= has_lit ? scan_ff[SEARCH_SIZE] : '0;
         lit_valid_ff <= has_lit;
         last_ff      <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_offset  = off_ff;
   assign rsp_match_length  = mlen_ff;
   assign rsp_literal_byte  = lit_ff;
   assign rsp_literal_valid = lit_valid_ff;
   assign rsp_token_last    = last_ff;

endmodule

// ----- hdl/lzse_ctrl.sv -----
module lzse_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stream_end,
   output logic                    req_ready,
   input  lzse_pkg::dp_status_type status,
   output lzse_pkg::dp_cmd_type    cmd
);
   import lzse_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      flush_ff;
   logic      flush_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      flush_in   = flush_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.write = 1'b1;
               if (req_stream_end) begin
                  flush_in = 1'b1;
                  state_in = ST_LOAD;
               end else if (status.fill_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_MATCH;
         end
         ST_MATCH: begin
            cmd.step = 1'b1;
            if (!status.step_go) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               cmd.last   = flush_ff && status.will_empty;
               if (flush_ff && !status.will_empty) begin
                  state_in = ST_LOAD;
               end else begin
                  flush_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            flush_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

endmodule

// ----- hdl/lz77_sliding_window_encoder.sv -----
// lz77 encoder with a 15-byte history and a 16-byte lookahead
// input channel req_*: one byte per item, req_stream_end set on the final byte
// output channel rsp_*: one token per item (offset, length, next byte, flags)
// bytes are taken one per cycle until the lookahead holds 16 bytes; then a
// token is built and req_ready stays low until it sits in the output register
// a token is built from the accept (or from the previous token during a flush):
// the window is copied into the scan register, the match step repeats while the
// next byte matches within the length limit, and the token is committed; the
// match step is the loop, all 15 offset comparators in parallel on each step
// stream_end flushes up to 16 tokens back to back; the last has token_last set,
// after which the history is empty and a new stream can start
// reset clears the fill counts and the output valid; window contents need none
// the result sits in an output register, so the next byte may be accepted
// while it waits; a stalled rsp_ready holds the token and blocks the next one
module lz77_sliding_window_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_match_offset,
   output logic [3:0] rsp_match_length,
   output logic [7:0] rsp_literal_byte,
   output logic       rsp_literal_valid,
   output logic       rsp_token_last
);
   import lzse_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lzse_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stream_end (req_stream_end),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   lzse_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_length  (rsp_match_length),
      .rsp_literal_byte  (rsp_literal_byte),
      .rsp_literal_valid (rsp_literal_valid),
      .rsp_token_last    (rsp_token_last)
   );

endmodule

// ----- hdl/lzse_checker.sv -----
`include "lz77_sliding_window_encoder_defines.svh"

module lzse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_stream_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_match_offset,
   input logic [3:0] rsp_match_length,
   input logic [7:0] rsp_literal_byte,
   input logic       rsp_literal_valid,
   input logic       rsp_token_last
);

   // a stalled token holds
   `LZSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_match_offset) && $stable(rsp_match_length) && $stable(rsp_literal_byte) && $stable(rsp_literal_valid) && $stable(rsp_token_last))

   // no match means no offset
   `LZSE_ASSERT_IMP(a_zero_len_off, rsp_valid && (rsp_match_length == 4'd0), rsp_match_offset == 4'd0)

   // a missing literal only ends a stream, and reads as zero
   `LZSE_ASSERT_IMP(a_no_lit_end, rsp_valid && !rsp_literal_valid, rsp_token_last && (rsp_literal_byte == 8'd0))

   // nothing is shown right after reset
   `LZSE_ASSERT_IMP(a_reset_quiet, $past(reset), !rsp_valid)

   // the final byte of a stream starts the flush and blocks the input
   `LZSE_ASSERT_NEXT(a_end_blocks, req_valid && req_ready && req_stream_end, !req_ready)

endmodule

bind lz77_sliding_window_encoder lzse_checker u_checker (.*);

// ----- dv/tb_lz77_sliding_window_encoder.sv -----
module tb_lz77_sliding_window_encoder;
   import lzse_pkg::*;

   typedef struct packed {
      byte_type data;
      logic     last_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0] offset;
      logic [3:0] length;
      byte_type   literal;
      logic       lit_valid;
      logic       last_tok;
   } token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_match_offset;
   logic [3:0] rsp_match_length;
   logic [7:0] rsp_literal_byte;
   logic       rsp_literal_valid;
   logic       rsp_token_last;

   lz77_sliding_window_encoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_match_length  (rsp_match_length),
      .rsp_literal_byte  (rsp_literal_byte),
      .rsp_literal_valid (rsp_literal_valid),
      .rsp_token_last    (rsp_token_last)
   );

   req_item_type bytes_to_send[$];
   token_type    tokens_due[$];
   byte_type     win_bytes[WIN_DEPTH];
   int           hist_len = 0;
   int           look_len = 0;
   int           total_items = 0;
   int           sent_cnt = 0;
   int           fail_cnt = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   req_item_type next_item;
   token_type    want;

   // longest match from the history, oldest position wins ties
   task automatic encode_token(input bit flushing);
      int        best_len;
      int        best_off;
      int        run;
      int        used;
      int        new_hist;
      int        drop;
      int        keep;
      token_type t;
      best_len = 0;
      best_off = 0;
      for (int i = 0; i < hist_len; i++) begin
         run = 0;
         while (run < MAX_MATCH && run < look_len &&
                win_bytes[i + run] == win_bytes[hist_len + run])
            run++;
         if (run > best_len) begin
            best_len = run;
            best_off = hist_len - i;
         end
      end
      t.lit_valid = (best_len < look_len);
      t.literal   = t.lit_valid ? win_bytes[hist_len + best_len] : 8'h00;
      t.offset    = 4'(best_off);
      t.length    = 4'(best_len);
      used        = t.lit_valid ? best_len + 1 : best_len;
      new_hist    = hist_len + used;
      if (new_hist > SEARCH_SIZE)
         new_hist = SEARCH_SIZE;
      drop = hist_len + used - new_hist;
      keep = hist_len + look_len - drop;
      if (drop > 0) begin
         for (int k = 0; k < keep; k++)
            win_bytes[k] = win_bytes[k + drop];
      end
      hist_len   = new_hist;
      look_len   = look_len - used;
      t.last_tok = flushing && (look_len == 0);
      tokens_due.push_back(t);
   endtask

   task automatic encode_byte(input byte_type b, input bit end_flag);
      if (look_len >= LOOK_SIZE)
         look_len = LOOK_SIZE - 1;
      win_bytes[hist_len + look_len] = b;
      look_len++;
      if (end_flag) begin
         while (look_len > 0)
            encode_token(1'b1);
         hist_len = 0;
         look_len = 0;
      end else if (look_len == LOOK_SIZE) begin
         encode_token(1'b0);
      end
   endtask

   task automatic add_byte(input byte_type b, input bit end_flag);
      req_item_type it;
      it.data      = b;
      it.last_byte = end_flag;
      bytes_to_send.push_back(it);
   endtask

   // random stream with content shaped to produce matches most of the time
   task automatic add_stream(input int len);
      int       mode;
      int       plen;
      byte_type sym_a;
      byte_type sym_b;
      byte_type pat[8];
      byte_type b;
      mode  = $urandom_range(0, 4);
      plen  = $urandom_range(1, 8);
      sym_a = 8'($urandom);
      sym_b = 8'($urandom);
      for (int k = 0; k < 8; k++)
         pat[k] = 8'($urandom);
      for (int n = 0; n < len; n++) begin
         case (mode)
            0: b = 8'($urandom);
            1: b = $urandom_range(0, 1) ? sym_a : sym_b;
            2, 3: begin
               b = pat[n % plen];
               if ($urandom_range(0, 15) == 0)
                  b = 8'($urandom);
            end
            default: b = ($urandom_range(0, 9) == 0) ? sym_b : sym_a;
         endcase
         add_byte(b, n == len - 1);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_data_byte  <= 8'h00;
         req_stream_end <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_stream_end);
            sent_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
               next_item = bytes_to_send.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= next_item.data;
               req_stream_end <= next_item.last_byte;
               if (bytes_to_send.size() >= 40 && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tokens_due.size() == 0) begin
               $error("unexpected token offset %0d length %0d literal %0d",
                      rsp_match_offset, rsp_match_length, rsp_literal_byte);
               fail_cnt++;
            end else begin
               want = tokens_due.pop_front();
               if (rsp_match_offset !== want.offset) begin
                  $error("match_offset expected %0d actual %0d", want.offset,
                         rsp_match_offset);
                  fail_cnt++;
               end
               if (rsp_match_length !== want.length) begin
                  $error("match_length expected %0d actual %0d", want.length,
                         rsp_match_length);
                  fail_cnt++;
               end
               if (rsp_literal_byte !== want.literal) begin
                  $error("literal_byte expected %0d actual %0d", want.literal,
                         rsp_literal_byte);
                  fail_cnt++;
               end
               if (rsp_literal_valid !== want.lit_valid) begin
                  $error("literal_valid expected %0d actual %0d", want.lit_valid,
                         rsp_literal_valid);
                  fail_cnt++;
               end
               if (rsp_token_last !== want.last_tok) begin
                  $error("token_last expected %0d actual %0d", want.last_tok,
                         rsp_token_last);
                  fail_cnt++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (bytes_to_send.size() >= 40 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      // one-byte stream at the top value
      add_byte(8'hff, 1'b1);
      // match that runs to the end of the stream, no next byte
      add_byte(8'h41, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'h41, 1'b0);
      add_byte(8'h41, 1'b1);
      // full lookahead, longest match, then a tie resolved to the oldest position
      for (int n = 0; n < 18; n++)
         add_byte(8'h00, n == 17);
      while (bytes_to_send.size() < 245) begin
         if ($urandom_range(0, 5) == 0)
            add_stream($urandom_range(40, 80));
         else
            add_stream($urandom_range(1, 40));
      end
      total_items = bytes_to_send.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (sent_cnt < total_items)
         @(posedge clock);
      while (tokens_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (fail_cnt == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- lz77_sliding_window_encoder.f -----
+incdir+hdl
hdl/lzse_pkg.sv
hdl/lzse_dp.sv
hdl/lzse_ctrl.sv
hdl/lz77_sliding_window_encoder.sv
hdl/lzse_checker.sv
dv/tb_lz77_sliding_window_encoder.sv
